// ----- hw/rtl/cepg_pkg.sv -----
// Shared constants, pipeline record types and the root-search step
// for the canonical ellipse point generator. No dependencies.
package cepg_pkg;

	localparam int COORD_WIDTH  = 12;
	localparam int RADIUS_WIDTH = 10;

	localparam int CW = COORD_WIDTH;
	localparam int RW = RADIUS_WIDTH;
	localparam int NB = RW + 1;           // bits of a rounded root
	localparam int DW = 2 * RW + 1;       // weight d: a^2 + b^2 or divisor^2
	localparam int LW = 4 * RW + 2;       // limit 4 * r
	localparam int QW = 4 * RW + 6;       // signed running products d*odd^2, d*odd
	localparam int NS = NB + 4;           // pipeline depth in stages

	typedef struct packed {
		logic          op;
		logic [CW-2:0] cx;
		logic [CW-2:0] cy;
		logic [RW-1:0] k;
		logic          dz;                // divisor axis is zero
	} item_t;

	typedef struct packed {
		logic [2*RW-1:0] a2;
		logic [2*RW-1:0] b2;
		logic [2*RW-1:0] k2;
	} sq_t;

	typedef struct packed {
		logic [DW-1:0]   sum2;            // a^2 + b^2
		logic [2*RW-1:0] div2;
		logic [2*RW-1:0] oth2;
		logic [2*RW-1:0] rest;            // div^2 - k^2, clamped at zero
	} sel_t;

	// Running state of one half-up root search: n is the root found so far,
	// q = d*(2n-1)^2 and l = d*(2n-1).
	typedef struct packed {
		logic [DW-1:0]        d;
		logic [LW-1:0]        lim;
		logic signed [QW-1:0] q;
		logic signed [QW-1:0] l;
		logic [NB-1:0]        n;
	} root_t;

	function automatic root_t root_init(logic [DW-1:0] d, logic [LW-1:0] lim);
		root_t r;
		r.d   = d;
		r.lim = lim;
		r.q   = $signed(QW'(d));
		r.l   = -$signed(QW'(d));
		r.n   = '0;
		return r;
	endfunction

	// Try bit j of n: odd grows by 2^(j+1), so
	// d*odd'^2 = q + l*2^(j+2) + d*2^(2j+2) and d*odd' = l + d*2^(j+1).
	function automatic root_t root_step(root_t r, int unsigned j);
		root_t                o;
		logic signed [QW-1:0] dq;
		logic signed [QW-1:0] qc;
		o  = r;
		dq = $signed(QW'(r.d));
		qc = r.q + (r.l <<< (j + 2)) + (dq <<< (2 * j + 2));
		if (qc <= $signed(QW'(r.lim))) begin
			o.q = qc;
			o.l = r.l + (dq <<< (j + 1));
			o.n = r.n | (NB'(1) << j);
		end
		return o;
	endfunction

endpackage

// ----- hw/rtl/canonical_ellipse_point_generator.sv -----
// Canonical ellipse point generator: one first-quadrant pixel per request.
// Depends on cepg_pkg (constants, record types, root-search step).
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+-----------------
//  in      | in_valid in_ready op center_x center_y          | point request
//          | radius_x radius_y step_offset                   |
//  out     | out_valid out_ready pixel_x pixel_y in_range    | computed pixel
//          | is_last                                         |
//
// Takes one request per cycle unless every stage is full and the output stalls.
// Stages: squares, select/subtract, 42-bit products, one stage per
// bit of the two rounded roots, and the output register.
// arst_n clears only the stage valid bits; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and a request is still taken while a finished pixel waits.
module canonical_ellipse_point_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [cepg_pkg::CW-2:0]       center_x,
	input  logic [cepg_pkg::CW-2:0]       center_y,
	input  logic [cepg_pkg::RW-1:0]       radius_x,
	input  logic [cepg_pkg::RW-1:0]       radius_y,
	input  logic [cepg_pkg::RW-1:0]       step_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cepg_pkg::CW-1:0]       pixel_x,
	output logic [cepg_pkg::CW-1:0]       pixel_y,
	output logic                          in_range,
	output logic                          is_last
);
	import cepg_pkg::*;

	// valid bit and advance enable of every stage, stage 1 .. NS
	logic [NS:1] vld_s;
	logic [NS:1] rdy;

	item_t item_s1, item_s2;
	sq_t   sq_s1;
	sel_t  sel_s2;

	// index g holds stage 3 + g: g = 0 is the seeded search, g = NB is done
	item_t item_sr [0:NB];
	root_t rb_sr   [0:NB];   // border root
	root_t rp_sr   [0:NB];   // perpendicular offset root

	logic [NB-1:0] border;
	logic [NB-1:0] perp;

	// ---------------- handshake: a stage advances when it is empty or drains
	assign rdy[NS]  = !vld_s[NS] || out_ready;
	generate
		for (genvar i = 1; i < NS; i++) begin : g_rdy
			assign rdy[i] = !vld_s[i] || rdy[i+1];
		end
	endgenerate
	assign in_ready  = rdy[1];
	assign out_valid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = NS; i >= 2; i--) begin
				if (rdy[i])
					vld_s[i] <= vld_s[i-1];
			end
			if (rdy[1])
				vld_s[1] <= in_valid;
		end
	end

	// ---------------- stage 1: squares of the radii and the offset
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			item_s1.op <= op;
			item_s1.cx <= center_x;
			item_s1.cy <= center_y;
			item_s1.k  <= step_offset;
			item_s1.dz <= op ? (radius_y == '0) : (radius_x == '0);
			sq_s1.a2   <= (2*RW)'(radius_x) * (2*RW)'(radius_x);
			sq_s1.b2   <= (2*RW)'(radius_y) * (2*RW)'(radius_y);
			sq_s1.k2   <= (2*RW)'(step_offset) * (2*RW)'(step_offset);
		end
	end

	// ---------------- stage 2: pick divisor axis, clamp the radicand
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			item_s2        <= item_s1;
			sel_s2.sum2    <= DW'(sq_s1.a2) + DW'(sq_s1.b2);
			sel_s2.div2    <= item_s1.op ? sq_s1.b2 : sq_s1.a2;
			sel_s2.oth2    <= item_s1.op ? sq_s1.a2 : sq_s1.b2;
			if (item_s1.op)
				sel_s2.rest <= (sq_s1.k2 < sq_s1.b2) ? sq_s1.b2 - sq_s1.k2 : '0;
			else
				sel_s2.rest <= (sq_s1.k2 < sq_s1.a2) ? sq_s1.a2 - sq_s1.k2 : '0;
		end
	end

	// ---------------- stage 3: limits 4*div^4 and 4*oth^2*rest, seed searches
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			item_sr[0] <= item_s2;
			rb_sr[0]   <= root_init(sel_s2.sum2,
				(LW'(sel_s2.div2) * LW'(sel_s2.div2)) << 2);
			rp_sr[0]   <= root_init(DW'(sel_s2.div2),
				(LW'(sel_s2.oth2) * LW'(sel_s2.rest)) << 2);
		end
	end

	// ---------------- stages 4 .. NB+3: one root bit per stage, MSB first
	generate
		for (genvar g = 1; g <= NB; g++) begin : g_root
			always_ff @(posedge clk) begin
				if (rdy[3+g]) begin
					item_sr[g] <= item_sr[g-1];
					rb_sr[g]   <= root_step(rb_sr[g-1], NB - g);
					rp_sr[g]   <= root_step(rp_sr[g-1], NB - g);
				end
			end
		end
	endgenerate

	// ---------------- stage NS: place the pixel, flag the border
	// a zero divisor axis forces both roots to zero
	assign border = item_sr[NB].dz ? '0 : rb_sr[NB].n;
	assign perp   = item_sr[NB].dz ? '0 : rp_sr[NB].n;

	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			if (item_sr[NB].op) begin
				pixel_x <= CW'(item_sr[NB].cx) + CW'(perp);
				pixel_y <= CW'(item_sr[NB].cy) + CW'(item_sr[NB].k);
			end else begin
				pixel_x <= CW'(item_sr[NB].cx) + CW'(item_sr[NB].k);
				pixel_y <= CW'(item_sr[NB].cy) + CW'(perp);
			end
			in_range <= NB'(item_sr[NB].k) <= border;
			is_last  <= NB'(item_sr[NB].k) == border;
		end
	end

	// ---------------- checks
	a_last_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> in_range)
		else $error("last step flagged outside the border");

	a_drain_opens_input : assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the output drains");

	a_stall_needs_bubble : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_ready |-> $countones(vld_s) < NS)
		else $error("request taken with every stage full and stalled");

	a_seed_root_zero : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] |-> rb_sr[0].n == '0 && rp_sr[0].n == '0)
		else $error("root search seeded with a nonzero root");

endmodule

// ----- sim/canonical_ellipse_point_generator_test.sv -----
// Self-checking test of canonical_ellipse_point_generator: random and directed point requests,
// predicted pixels compared field by field at the output channel.
// Depends on cepg_pkg and the block itself.
module canonical_ellipse_point_generator_test;

	import cepg_pkg::*;

	localparam int CW          = cepg_pkg::CW;
	localparam int RW          = cepg_pkg::RW;
	localparam int N_RANDOM    = 1830;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_WAIT  = 40;       // well past the pipeline depth
	localparam int HOLD_CYCLES = 80;       // long enough to fill every stage

	typedef struct {
		logic          op;
		logic [CW-2:0] cx;
		logic [CW-2:0] cy;
		logic [RW-1:0] a;
		logic [RW-1:0] b;
		logic [RW-1:0] k;
	} request_t;

	typedef struct {
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic          in_range;
		logic          is_last;
	} pixel_t;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          in_valid    = 1'b0;
	logic          in_ready;
	logic          op          = 1'b0;
	logic [CW-2:0] center_x    = '0;
	logic [CW-2:0] center_y    = '0;
	logic [RW-1:0] radius_x    = '0;
	logic [RW-1:0] radius_y    = '0;
	logic [RW-1:0] step_offset = '0;
	logic          out_valid;
	logic          out_ready   = 1'b0;
	logic [CW-1:0] pixel_x;
	logic [CW-1:0] pixel_y;
	logic          in_range;
	logic          is_last;

	request_t requests_todo[$];   // requests not yet offered
	pixel_t   pixels_due[$];      // predicted pixels, oldest first
	request_t offered;
	pixel_t   want;
	int       mismatches  = 0;
	int       pixels_seen = 0;
	int       hold_left   = 0;
	int       cycles      = 0;

	canonical_ellipse_point_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.step_offset (step_offset),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.in_range    (in_range),
		.is_last     (is_last)
	);

	// Largest n with n == 0 or (2n-1)^2 * w <= 4 * r, i.e. sqrt(r/w) rounded half up.
	// Search the bits from the top; every product stays well inside 64 bits.
	function automatic longint unsigned nearest_root(longint unsigned w, longint unsigned r);
		longint unsigned n;
		longint unsigned trial;
		longint unsigned odd;
		n = 0;
		for (int j = RW; j >= 0; j--) begin
			trial = n | (64'd1 << j);
			odd   = 2 * trial - 1;
			if (odd * odd * w <= 4 * r)
				n = trial;
		end
		return n;
	endfunction

	// Last offset of the part: round(div^2 / sqrt(a^2 + b^2)), zero for a zero divisor axis.
	function automatic longint unsigned part_border(request_t r);
		longint unsigned a;
		longint unsigned b;
		longint unsigned dv2;
		a   = 64'(r.a);
		b   = 64'(r.b);
		dv2 = r.op ? b * b : a * a;
		if (dv2 == 0)
			return 0;
		return nearest_root(a * a + b * b, dv2 * dv2);
	endfunction

	// Pixel the block must produce for one request.
	function automatic pixel_t compute_pixel(request_t r);
		longint unsigned k;
		longint unsigned dv;
		longint unsigned ot;
		longint unsigned rest;
		longint unsigned perp;
		longint unsigned brd;
		longint unsigned sx;
		longint unsigned sy;
		pixel_t          p;
		k    = 64'(r.k);
		dv   = 64'(r.op ? r.b : r.a);
		ot   = 64'(r.op ? r.a : r.b);
		perp = 0;
		if (dv != 0) begin
			// clamp the radicand at zero once k reaches the divisor axis
			rest = (k * k < dv * dv) ? dv * dv - k * k : 0;
			perp = nearest_root(dv * dv, ot * ot * rest);
		end
		brd = part_border(r);
		if (!r.op) begin
			sx = longint'(r.cx) + k;
			sy = longint'(r.cy) + perp;
		end else begin
			sx = longint'(r.cx) + perp;
			sy = longint'(r.cy) + k;
		end
		p.px       = sx[CW-1:0];
		p.py       = sy[CW-1:0];
		p.in_range = (k <= brd);
		p.is_last  = (k == brd);
		return p;
	endfunction

	task automatic queue_request(input logic o, input int cx, input int cy,
			input int a, input int b, input int k);
		request_t r;
		r.op = o;
		r.cx = cx[CW-2:0];
		r.cy = cy[CW-2:0];
		r.a  = a[RW-1:0];
		r.b  = b[RW-1:0];
		r.k  = k[RW-1:0];
		requests_todo.insert(requests_todo.size(), r);
	endtask

	// Random request aimed at the interesting offsets: inside the divisor axis,
	// around the border, and around the axis end where the radicand clamps.
	task automatic queue_random();
		request_t r;
		int       pick;
		int       a;
		int       b;
		int       dv;
		int       kk;
		pick = $urandom_range(9);
		if (pick < 2) begin
			a = $urandom_range(16, 1);
			b = $urandom_range(16, 1);
		end else if (pick < 4) begin
			a = $urandom_range(1023, 1);
			b = a;                          // circle
		end else begin
			a = $urandom_range(1023, 1);
			b = $urandom_range(1023, 1);
		end
		r.op = 1'($urandom_range(1));
		r.cx = (CW-1)'($urandom_range(2047));
		r.cy = (CW-1)'($urandom_range(2047));
		r.a  = a[RW-1:0];
		r.b  = b[RW-1:0];
		r.k  = '0;
		dv   = r.op ? b : a;
		case ($urandom_range(9))
			0, 1: kk = $urandom_range(1023);
			2, 3, 4, 5: kk = $urandom_range(dv);
			6, 7, 8: kk = int'(part_border(r)) + int'($urandom_range(4)) - 2;
			default: kk = dv + int'($urandom_range(2)) - 1;
		endcase
		if (kk < 0)
			kk = 0;
		if (kk > 1023)
			kk = 1023;
		r.k = kk[RW-1:0];
		requests_todo.insert(requests_todo.size(), r);
	endtask

	task automatic check_field(input string name, input logic [CW-1:0] got,
			input logic [CW-1:0] exp_val);
		if (got !== exp_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
		end
	endtask

	// Idle at random except in a calm window in the middle of the run.
	function automatic bit take_break();
		if (cycles >= 800 && cycles < 1600)
			return 1'b0;
		return $urandom_range(99) < 16;
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// Bound the run no matter what the block does.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Driver: record the prediction for an accepted request, then offer the next one
	// or go idle. Hold the payload steady while a request waits for in_ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				pixels_due.insert(pixels_due.size(), compute_pixel(offered));
			if (!in_valid || in_ready) begin
				if (requests_todo.size() != 0 && !take_break()) begin
					offered     <= requests_todo[0];
					op          <= requests_todo[0].op;
					center_x    <= requests_todo[0].cx;
					center_y    <= requests_todo[0].cy;
					radius_x    <= requests_todo[0].a;
					radius_y    <= requests_todo[0].b;
					step_offset <= requests_todo[0].k;
					in_valid    <= 1'b1;
					void'(requests_todo.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare every accepted pixel with the oldest prediction and drive
	// out_ready. Twice in the run, drop out_ready for a long stretch so the
	// pipeline fills and the block must stall its input side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					mismatches++;
					$display("%0t: pixel (%0d, %0d) with no request pending", $time,
						pixel_x, pixel_y);
				end else begin
					want = pixels_due.pop_front();
					check_field("pixel_x", pixel_x, want.px);
					check_field("pixel_y", pixel_y, want.py);
					check_field("in_range", CW'(in_range), CW'(want.in_range));
					check_field("is_last", CW'(is_last), CW'(want.is_last));
				end
				pixels_seen++;
				if (pixels_seen == 200 || pixels_seen == 1700)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !take_break();
			end
		end
	end

	initial begin
		// Directed part, both parts each: smallest circle, largest circle around its
		// border and at the axis end, flat ellipses, offsets past the border and
		// beyond the divisor axis, extreme centres.
		for (int o = 0; o < 2; o++) begin
			queue_request(1'(o), 0, 0, 1, 1, 0);
			queue_request(1'(o), 0, 0, 1, 1, 1);
			queue_request(1'(o), 2047, 2047, 1023, 1023, 0);
			queue_request(1'(o), 2047, 2047, 1023, 1023, 723);
			queue_request(1'(o), 2047, 2047, 1023, 1023, 724);
			queue_request(1'(o), 2047, 2047, 1023, 1023, 1023);
			queue_request(1'(o), 100, 200, 1023, 1, 0);
			queue_request(1'(o), 85, 85, 1023, 1, 1023);
			queue_request(1'(o), 1234, 567, 1, 1023, 1023);
			queue_request(1'(o), 0, 2047, 5, 3, 4);
		end
		for (int i = 0; i < N_RANDOM; i++)
			queue_random();

		// Hold reset, then release it once.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request is taken and every pixel has come back.
		while (requests_todo.size() != 0 || in_valid || pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0 && pixels_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
